/* hdl/pacl_pkg.sv */
// ----------------------------------------------------------------------------
// pacl_pkg: shared definitions of the pool allocator with class lists
// Field widths, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package pacl_pkg;

  localparam int OP_W     = 2;
  localparam int LIST_W   = 4;
  localparam int ENTRY_W  = 8;
  localparam int STATUS_W = 2;

  localparam int POOL_SIZE_DEF = 256;
  localparam int NUM_LISTS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FIRST = 2'd2,
    OP_NEXT  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_END        = 2'd3
  } status_t;

endpackage

/* hdl/pacl_req_if.sv */
// ----------------------------------------------------------------------------
// pacl_req_if: request channel
// Carries one allocator request per transaction.
// ----------------------------------------------------------------------------
interface pacl_req_if;
  logic                         valid;
  logic                         ready;
  logic [pacl_pkg::OP_W-1:0]    opcode;
  logic [pacl_pkg::LIST_W-1:0]  list_id;
  logic [pacl_pkg::ENTRY_W-1:0] entry_id;

  modport source (output valid, opcode, list_id, entry_id, input ready);
  modport sink   (input valid, opcode, list_id, entry_id, output ready);
endinterface

/* hdl/pacl_rsp_if.sv */
// ----------------------------------------------------------------------------
// pacl_rsp_if: response channel
// Carries one allocator response per transaction.
// ----------------------------------------------------------------------------
interface pacl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pacl_pkg::STATUS_W-1:0] status;
  logic [pacl_pkg::ENTRY_W-1:0]  result_entry;

  modport source (output valid, status, result_entry, input ready);
  modport sink   (input valid, status, result_entry, output ready);
endinterface

/* hdl/pool_allocator_with_class_lists.sv */
// ----------------------------------------------------------------------------
// pool_allocator_with_class_lists: pool allocator with doubly linked lists
// A LIFO free chain and NUM_LISTS in-use lists kept in link memories.
// ----------------------------------------------------------------------------
// One request is worked on at a time and gives one response. A first-of-list
// or next-of-entry query is answered from state S_FQ or S_NQ. An allocation
// into an empty list, a free of an entry at the head of its list, and an
// allocation or free that is refused finish in S_AL1 or S_FR1. Any other
// allocation or free goes on to S_AL2 or S_FR2, because the successor link
// memory has a single write port and such a request rewrites two of its words.
// Each request reads its memory words in the cycle it is accepted and writes
// back in the cycles after. A fill mark stands in for the reset of the link
// memories, so there is no clearing pass after reset. A new request is taken
// while a response still waits in the output register.
module pool_allocator_with_class_lists #(
  parameter int POOL_SIZE = pacl_pkg::POOL_SIZE_DEF,
  parameter int NUM_LISTS = pacl_pkg::NUM_LISTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pacl_req_if.sink   req,
  pacl_rsp_if.source rsp
);

  localparam int IW  = $clog2(POOL_SIZE);
  localparam int LW  = $clog2(POOL_SIZE + 1);
  localparam int LIW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_AL1  = 7'b0000010,
    S_AL2  = 7'b0000100,
    S_FR1  = 7'b0001000,
    S_FR2  = 7'b0010000,
    S_FQ   = 7'b0100000,
    S_NQ   = 7'b1000000
  } state_t;

  logic [LW-1:0]  nxt_mem  [POOL_SIZE];
  logic [LW-1:0]  prv_mem  [POOL_SIZE];
  logic [LIW-1:0] own_mem  [POOL_SIZE];
  logic           use_mem  [POOL_SIZE];
  logic [LW-1:0]  head_mem [NUM_LISTS];
  logic [LW-1:0]  tail_mem [NUM_LISTS];
  logic [NUM_LISTS-1:0] lst_vld;

  state_t state, state_next;
  logic [LW-1:0]  free_top, free_top_next;
  logic [LW-1:0]  hwm, hwm_next;
  logic [IW-1:0]  work, work_next;
  logic [LW-1:0]  link, link_next;
  logic [LIW-1:0] lst_q;
  logic           lst_ok_q;
  logic [IW-1:0]  ent_q;
  logic           ent_ok_q;

  logic [LW-1:0]  nxt_rd, prv_rd, head_rd, tail_rd;
  logic [LIW-1:0] own_rd;
  logic           use_rd;

  logic           acc;
  logic [IW-1:0]  ent_ra;
  logic [LIW-1:0] lst_ra;

  logic           nxt_we, prv_we, own_we, use_we, head_we, tail_we, vld_set;
  logic [IW-1:0]  nxt_wa, prv_wa, own_wa, use_wa;
  logic [LW-1:0]  nxt_wd, prv_wd, head_wd, tail_wd;
  logic [LIW-1:0] own_wd, head_wa, tail_wa;
  logic           use_wd;

  logic                   fin;
  pacl_pkg::status_t      fin_st;
  logic [IW-1:0]          fin_ent;
  logic                   used;
  logic [LW-1:0]          tail_now;

  logic                   out_vld, pend;
  pacl_pkg::status_t      out_st, pend_st;
  logic [IW-1:0]          out_ent, pend_ent;
  logic                   slot_free;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !pend;
  assign slot_free = !out_vld || rsp.ready;
  assign ent_ra    = (req.opcode == pacl_pkg::OP_ALLOC) ? IW'(free_top) : IW'(req.entry_id);
  assign lst_ra    = LIW'(req.list_id);

  assign rsp.valid        = out_vld;
  assign rsp.status       = out_st;
  assign rsp.result_entry = (out_st == pacl_pkg::ST_OK) ? pacl_pkg::ENTRY_W'(out_ent) : '0;

  assign used     = ent_ok_q && (LW'(ent_q) < hwm) && use_rd;
  assign tail_now = (lst_ok_q && lst_vld[lst_q]) ? tail_rd : NIL;

  always_comb begin
    state_next    = state;
    free_top_next = free_top;
    hwm_next      = hwm;
    work_next     = work;
    link_next     = link;
    fin           = 1'b0;
    fin_st        = pacl_pkg::ST_OK;
    fin_ent       = work;
    nxt_we = 1'b0; nxt_wa = ent_q; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = ent_q; prv_wd = NIL;
    own_we = 1'b0; own_wa = ent_q; own_wd = lst_q;
    use_we = 1'b0; use_wa = ent_q; use_wd = 1'b0;
    head_we = 1'b0; head_wa = lst_q; head_wd = NIL;
    tail_we = 1'b0; tail_wa = lst_q; tail_wd = NIL;
    vld_set = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (req.opcode)
            pacl_pkg::OP_ALLOC: state_next = S_AL1;
            pacl_pkg::OP_FREE:  state_next = S_FR1;
            pacl_pkg::OP_FIRST: state_next = S_FQ;
            pacl_pkg::OP_NEXT:  state_next = S_NQ;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_AL1: begin
        if (!lst_ok_q || free_top == NIL) begin
          fin        = 1'b1;
          fin_st     = pacl_pkg::ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          free_top_next = (free_top >= hwm) ? free_top + LW'(1) : nxt_rd;
          if (free_top == hwm) begin
            hwm_next = hwm + LW'(1);
          end
          work_next = IW'(free_top);
          link_next = tail_now;
          nxt_we = 1'b1; nxt_wa = IW'(free_top); nxt_wd = NIL;
          prv_we = 1'b1; prv_wa = IW'(free_top); prv_wd = tail_now;
          own_we = 1'b1; own_wa = IW'(free_top); own_wd = lst_q;
          use_we = 1'b1; use_wa = IW'(free_top); use_wd = 1'b1;
          tail_we = 1'b1; tail_wa = lst_q; tail_wd = free_top;
          vld_set = 1'b1;
          if (tail_now == NIL) begin
            head_we    = 1'b1;
            head_wa    = lst_q;
            head_wd    = free_top;
            fin        = 1'b1;
            fin_ent    = IW'(free_top);
            state_next = S_IDLE;
          end else begin
            state_next = S_AL2;
          end
        end
      end
      S_AL2: begin
        nxt_we     = 1'b1;
        nxt_wa     = IW'(link);
        nxt_wd     = LW'(work);
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_FR1: begin
        if (!used) begin
          fin        = 1'b1;
          fin_st     = pacl_pkg::ST_NOT_IN_USE;
          state_next = S_IDLE;
        end else begin
          work_next = ent_q;
          use_we = 1'b1; use_wa = ent_q; use_wd = 1'b0;
          if (nxt_rd == NIL) begin
            tail_we = 1'b1; tail_wa = own_rd; tail_wd = prv_rd;
          end else begin
            prv_we = 1'b1; prv_wa = IW'(nxt_rd); prv_wd = prv_rd;
          end
          if (prv_rd == NIL) begin
            head_we = 1'b1; head_wa = own_rd; head_wd = nxt_rd;
            nxt_we = 1'b1; nxt_wa = ent_q; nxt_wd = free_top;
            free_top_next = LW'(ent_q);
            fin           = 1'b1;
            fin_ent       = ent_q;
            state_next    = S_IDLE;
          end else begin
            nxt_we = 1'b1; nxt_wa = IW'(prv_rd); nxt_wd = nxt_rd;
            state_next = S_FR2;
          end
        end
      end
      S_FR2: begin
        nxt_we        = 1'b1;
        nxt_wa        = work;
        nxt_wd        = free_top;
        free_top_next = LW'(work);
        fin           = 1'b1;
        state_next    = S_IDLE;
      end
      S_FQ: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        if (lst_ok_q && lst_vld[lst_q] && head_rd != NIL) begin
          fin_ent = IW'(head_rd);
        end else begin
          fin_st = pacl_pkg::ST_END;
        end
      end
      S_NQ: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        if (!used) begin
          fin_st = pacl_pkg::ST_NOT_IN_USE;
        end else if (nxt_rd == NIL) begin
          fin_st = pacl_pkg::ST_END;
        end else begin
          fin_ent = IW'(nxt_rd);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      nxt_rd  <= nxt_mem[ent_ra];
      prv_rd  <= prv_mem[ent_ra];
      own_rd  <= own_mem[ent_ra];
      use_rd  <= use_mem[ent_ra];
      head_rd <= head_mem[lst_ra];
      tail_rd <= tail_mem[lst_ra];
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      lst_q    <= LIW'(req.list_id);
      lst_ok_q <= 32'(req.list_id) < NUM_LISTS;
      ent_q    <= IW'(req.entry_id);
      ent_ok_q <= 32'(req.entry_id) < POOL_SIZE;
    end
    work <= work_next;
    link <= link_next;
    if (fin && !slot_free) begin
      pend_st  <= fin_st;
      pend_ent <= fin_ent;
    end
    if (fin && slot_free) begin
      out_st  <= fin_st;
      out_ent <= fin_ent;
    end else if (pend && slot_free) begin
      out_st  <= pend_st;
      out_ent <= pend_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      free_top <= '0;
      hwm      <= '0;
      lst_vld  <= '0;
      out_vld  <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      free_top <= free_top_next;
      hwm      <= hwm_next;
      if (vld_set) begin
        lst_vld[lst_q] <= 1'b1;
      end
      if (fin) begin
        if (slot_free) begin
          out_vld <= 1'b1;
        end else begin
          pend <= 1'b1;
        end
      end else if (pend && slot_free) begin
        out_vld <= 1'b1;
        pend    <= 1'b0;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_hwm_bound: assert property (@(posedge clk) disable iff (rst) hwm <= NIL)
    else $error("fill mark beyond pool size");

  a_free_top: assert property (@(posedge clk) disable iff (rst)
    (free_top <= hwm) || (free_top == NIL))
    else $error("free chain top above fill mark");

  a_pend_out: assert property (@(posedge clk) disable iff (rst) pend |-> out_vld)
    else $error("pending response without a response in the output register");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state != S_IDLE))
    else $error("accepted transaction not worked on");

  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    fin |=> (state == S_IDLE) && !fin)
    else $error("response finished twice");
`endif

endmodule

/* verif/pacl_alloc_checker.sv */
// ----------------------------------------------------------------------------
// pacl_alloc_checker: response checker for the pool allocator
// Watches the request and response channels and keeps its own copy of the
// free chain and the class lists. Each accepted request is turned into the
// response it must produce, and each accepted response is compared, field by
// field, with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pacl_alloc_checker
  import pacl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pacl_req_if  req,
  pacl_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int NIL = POOL_SIZE_DEF;

  typedef struct packed {
    status_t               status;
    logic [ENTRY_W-1:0]    entry;
  } outcome_t;

  int unsigned succ [NIL];
  int unsigned pred [NIL];
  int unsigned owner [NIL];
  logic        in_use [NIL];
  int unsigned head [NUM_LISTS_DEF];
  int unsigned tail [NUM_LISTS_DEF];
  int unsigned free_top;

  outcome_t awaited_responses [$];
  int       fail_total = 0;

  task automatic report_mismatch(string what);
    $display("%0t ns pacl mismatch: %s", $time, what);
    fail_total++;
  endtask

  function automatic outcome_t make_outcome(status_t st, int unsigned ent);
    outcome_t o;
    o.status = st;
    o.entry  = (st == ST_OK) ? ent[ENTRY_W-1:0] : '0;
    return o;
  endfunction

  function automatic outcome_t predict_grant(int unsigned lst);
    int unsigned ent;
    int unsigned last;
    if (lst >= NUM_LISTS_DEF || free_top >= NIL) return make_outcome(ST_EMPTY, 0);
    ent       = free_top;
    free_top  = succ[ent];
    last      = tail[lst];
    pred[ent] = last;
    succ[ent] = NIL;
    if (last >= NIL) head[lst] = ent;
    else succ[last] = ent;
    tail[lst]   = ent;
    owner[ent]  = lst;
    in_use[ent] = 1'b1;
    return make_outcome(ST_OK, ent);
  endfunction

  function automatic outcome_t predict_release(int unsigned ent);
    int unsigned p;
    int unsigned n;
    int unsigned lst;
    if (ent >= NIL || !in_use[ent]) return make_outcome(ST_NOT_IN_USE, 0);
    p   = pred[ent];
    n   = succ[ent];
    lst = owner[ent];
    if (lst >= NUM_LISTS_DEF) lst = 0;
    if (p >= NIL) head[lst] = n;
    else succ[p] = n;
    if (n >= NIL) tail[lst] = p;
    else pred[n] = p;
    succ[ent]   = free_top;
    free_top    = ent;
    in_use[ent] = 1'b0;
    return make_outcome(ST_OK, ent);
  endfunction

  function automatic outcome_t predict_outcome(opcode_t op, int unsigned lst,
                                               int unsigned ent);
    int unsigned v;
    case (op)
      OP_ALLOC: return predict_grant(lst);
      OP_FREE:  return predict_release(ent);
      OP_FIRST: begin
        if (lst >= NUM_LISTS_DEF) return make_outcome(ST_END, 0);
        v = head[lst];
        if (v >= NIL) return make_outcome(ST_END, 0);
        return make_outcome(ST_OK, v);
      end
      default: begin
        if (ent >= NIL || !in_use[ent]) return make_outcome(ST_NOT_IN_USE, 0);
        v = succ[ent];
        if (v >= NIL) return make_outcome(ST_END, 0);
        return make_outcome(ST_OK, v);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < NIL; i++) begin
        succ[i]   = i + 1;
        pred[i]   = 0;
        owner[i]  = 0;
        in_use[i] = 1'b0;
      end
      for (int i = 0; i < NUM_LISTS_DEF; i++) begin
        head[i] = NIL;
        tail[i] = NIL;
      end
      free_top = 0;
      awaited_responses.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch($sformatf("response %0d/%0d with no request waiting",
                                    rsp.status, rsp.result_entry));
        end else begin
          want = awaited_responses.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %s",
                                      rsp.status, want.status.name()));
          if (rsp.result_entry !== want.entry)
            report_mismatch($sformatf("result_entry got %0d expected %0d",
                                      rsp.result_entry, want.entry));
        end
      end
      if (req.valid && req.ready)
        awaited_responses.push_back(predict_outcome(opcode_t'(req.opcode),
                                                    req.list_id, req.entry_id));
    end
    mismatches  <= fail_total;
    outstanding <= awaited_responses.size();
  end

endmodule

/* verif/pool_allocator_with_class_lists_test.sv */
// ----------------------------------------------------------------------------
// pool_allocator_with_class_lists_test: testbench of the pool allocator
// Drives a directed sequence over the special cases, then random phases that
// fill the pool until it runs empty, drain it and mix the operations, with
// random gaps on both channels. The checker beside the block judges every
// response; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pool_allocator_with_class_lists_test;
  import pacl_pkg::*;

  logic clk = 1'b0;
  logic rst;

  pacl_req_if req_ch ();
  pacl_rsp_if rsp_ch ();

  int mismatches;
  int outstanding;

  bit      no_idle;
  bit      live [POOL_SIZE_DEF];
  int      live_count = 0;
  opcode_t sent_ops [$];

  always #5 clk = ~clk;

  pool_allocator_with_class_lists DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pacl_alloc_checker alloc_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    opcode_t op;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready && sent_ops.size() > 0) begin
        op = sent_ops.pop_front();
        if (rsp_ch.status == ST_OK && op == OP_ALLOC) begin
          live[rsp_ch.result_entry] <= 1'b1;
          live_count <= live_count + 1;
        end else if (rsp_ch.status == ST_OK && op == OP_FREE) begin
          live[rsp_ch.result_entry] <= 1'b0;
          live_count <= live_count - 1;
        end
      end
      if (req_ch.valid && req_ch.ready) sent_ops.push_back(opcode_t'(req_ch.opcode));
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_entry();
    int start;
    int idx;
    if (live_count > 0 && $urandom_range(0, 9) < 8) begin
      start = $urandom_range(0, POOL_SIZE_DEF - 1);
      for (int k = 0; k < POOL_SIZE_DEF; k++) begin
        idx = (start + k) % POOL_SIZE_DEF;
        if (live[idx]) return idx[ENTRY_W-1:0];
      end
    end
    return ENTRY_W'($urandom_range(0, (1 << ENTRY_W) - 1));
  endfunction

  function automatic logic [LIST_W-1:0] pick_list();
    if ($urandom_range(0, 1)) return LIST_W'($urandom_range(0, 3));
    return LIST_W'($urandom_range(0, (1 << LIST_W) - 1));
  endfunction

  task automatic issue(opcode_t op, logic [LIST_W-1:0] lst, logic [ENTRY_W-1:0] ent);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.list_id  <= lst;
    req_ch.entry_id <= ent;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int      alloc_pct [4];
    int      free_pct  [4];
    int      r;
    int      waited;
    opcode_t op;
    alloc_pct       = '{50, 85, 10, 40};
    free_pct        = '{25, 5, 75, 40};
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.opcode   <= OP_ALLOC;
    req_ch.list_id  <= '0;
    req_ch.entry_id <= '0;
    no_idle         = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    issue(OP_FIRST, 4'd0, 8'd0);
    issue(OP_FIRST, 4'd15, 8'd255);
    issue(OP_NEXT, 4'd0, 8'd0);
    issue(OP_FREE, 4'd0, 8'd255);
    issue(OP_FREE, 4'd15, 8'd0);
    issue(OP_ALLOC, 4'd0, 8'd0);
    issue(OP_NEXT, 4'd0, 8'd0);
    issue(OP_ALLOC, 4'd0, 8'd0);
    issue(OP_ALLOC, 4'd15, 8'd0);
    issue(OP_ALLOC, 4'd0, 8'd0);
    issue(OP_FIRST, 4'd0, 8'd0);
    issue(OP_NEXT, 4'd0, 8'd0);
    issue(OP_NEXT, 4'd0, 8'd1);
    issue(OP_NEXT, 4'd0, 8'd3);
    issue(OP_FREE, 4'd0, 8'd1);
    issue(OP_NEXT, 4'd0, 8'd0);
    issue(OP_FREE, 4'd0, 8'd3);
    issue(OP_FREE, 4'd0, 8'd0);
    issue(OP_FIRST, 4'd0, 8'd0);
    issue(OP_FREE, 4'd0, 8'd0);
    issue(OP_ALLOC, 4'd7, 8'd0);
    issue(OP_ALLOC, 4'd7, 8'd0);
    issue(OP_FREE, 4'd0, 8'd2);
    issue(OP_FIRST, 4'd15, 8'd0);
    issue(OP_FIRST, 4'd7, 8'd0);

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 350; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < alloc_pct[phase]) op = OP_ALLOC;
        else if (r < alloc_pct[phase] + free_pct[phase]) op = OP_FREE;
        else if (r[0]) op = OP_FIRST;
        else op = OP_NEXT;
        issue(op, pick_list(), pick_entry());
      end
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;
    @(posedge clk);

    waited = 0;
    while (outstanding != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
